### design/pitm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitm_pkg: shared types and constants for the pid to thread index map
// Function and status codes, table geometry, hash constant and the
// command and status structures between controller and datapath.
// ----------------------------------------------------------------------------
package pitm_pkg;

  localparam int HASH_BITS   = 8;
  localparam int SLOT_COUNT  = 1 << HASH_BITS;
  localparam int PID_W       = 22;
  localparam int IDX_W       = 8;
  localparam int INDEX_COUNT = 1 << IDX_W;
  localparam int CNT_W       = 9;
  localparam int FUNC_W      = 3;
  localparam int STATUS_W    = 2;

  localparam logic [31:0] HASH_MUL = 32'h61C88647;
  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(INDEX_COUNT);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 3'd0,
    FUNC_DELETE = 3'd1,
    FUNC_LOOKUP = 3'd2,
    FUNC_RLOOK  = 3'd3,
    FUNC_CLEAR  = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_COLLISION = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_EXEC = 2'd2
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic read;
    logic exec;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

### design/pitm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitm_ctrl: operation sequencer
// Steps each accepted operation through capture, table read and execute.
// ----------------------------------------------------------------------------
module pitm_ctrl
  import pitm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_EXEC;
      end
      S_EXEC: begin
        // Hold here until the result register can take the new result.
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### design/pitm_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitm_dpath: tables, counters and result register
// Hashes the pid, reads slot and reverse tables, applies the operation
// and loads the result register.
// ----------------------------------------------------------------------------
module pitm_dpath
  import pitm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  input  logic                cfg_we_i,
  input  logic [CNT_W-1:0]    cfg_thread_limit_i,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [PID_W-1:0]    pid_key_i,
  input  logic [IDX_W-1:0]    thread_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [IDX_W-1:0]    index_out_o,
  output logic [PID_W-1:0]    pid_out_o,
  output logic [CNT_W-1:0]    threads_issued_o,
  output logic [CNT_W-1:0]    threads_active_o
);

  // Configuration.
  logic [CNT_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_thread_limit_i;
    end
  end

  // Captured operation and hash.
  func_e                func_q;
  logic [PID_W-1:0]     pid_q;
  logic [IDX_W-1:0]     tix_q;
  logic [HASH_BITS-1:0] hash_q;
  logic [31:0]          prod;

  assign prod = 32'({{(32 - PID_W){1'b0}}, pid_key_i} * HASH_MUL);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_e'(func_i);
      pid_q  <= pid_key_i;
      tix_q  <= thread_index_i;
      hash_q <= prod[31 -: HASH_BITS];
    end
  end

  // Tables.
  logic [PID_W-1:0] slot_pid_mem [SLOT_COUNT];
  logic [IDX_W-1:0] slot_idx_mem [SLOT_COUNT];
  logic [PID_W-1:0] rev_pid_mem  [INDEX_COUNT];
  logic [SLOT_COUNT-1:0]  slot_valid_q;
  logic [INDEX_COUNT-1:0] rev_valid_q;
  logic [PID_W-1:0] slot_pid_rd_q;
  logic [IDX_W-1:0] slot_idx_rd_q;
  logic [PID_W-1:0] rev_pid_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      slot_pid_rd_q <= slot_pid_mem[hash_q];
      slot_idx_rd_q <= slot_idx_mem[hash_q];
      rev_pid_rd_q  <= rev_pid_mem[tix_q];
    end
  end

  // Counters.
  logic [CNT_W-1:0] issued_q, active_q;
  logic [CNT_W-1:0] limit_eff;
  logic [IDX_W-1:0] new_idx;
  logic             slot_hit;
  logic             add_ok, del_ok;

  assign limit_eff = (limit_q > CNT_W'(INDEX_COUNT)) ? CNT_W'(INDEX_COUNT) : limit_q;
  assign new_idx   = issued_q[IDX_W-1:0];
  assign slot_hit  = slot_valid_q[hash_q] && (slot_pid_rd_q == pid_q);
  assign add_ok    = (func_q == FUNC_ADD) && (issued_q < limit_eff) && !slot_valid_q[hash_q];
  assign del_ok    = (func_q == FUNC_DELETE) && slot_hit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && add_ok) begin
      slot_pid_mem[hash_q] <= pid_q;
      slot_idx_mem[hash_q] <= new_idx;
      rev_pid_mem[new_idx] <= pid_q;
    end
  end

  logic [CNT_W-1:0] issued_d, active_d;

  always_comb begin
    issued_d = issued_q;
    active_d = active_q;
    if (add_ok) begin
      issued_d = issued_q + 1'b1;
      active_d = active_q + 1'b1;
    end else if (del_ok && (active_q != '0)) begin
      active_d = active_q - 1'b1;
    end else if (func_q == FUNC_CLEAR) begin
      issued_d = '0;
      active_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      rev_valid_q  <= '0;
      issued_q     <= '0;
      active_q     <= '0;
    end else if (cmd_i.exec) begin
      issued_q <= issued_d;
      active_q <= active_d;
      if (func_q == FUNC_CLEAR) begin
        slot_valid_q <= '0;
        rev_valid_q  <= '0;
      end else if (add_ok) begin
        slot_valid_q[hash_q] <= 1'b1;
        rev_valid_q[new_idx] <= 1'b1;
      end else if (del_ok) begin
        slot_valid_q[hash_q] <= 1'b0;
      end
    end
  end

  // Result selection.
  status_e          status_d;
  logic [IDX_W-1:0] index_d;
  logic [PID_W-1:0] pid_d;

  always_comb begin
    status_d = ST_OK;
    index_d  = '0;
    pid_d    = '0;
    case (func_q)
      FUNC_ADD: begin
        if (issued_q >= limit_eff) begin
          status_d = ST_LIMIT;
        end else if (slot_valid_q[hash_q]) begin
          status_d = ST_COLLISION;
        end else begin
          index_d = new_idx;
        end
      end
      FUNC_DELETE: begin
        if (!slot_hit) begin
          status_d = ST_NOT_FOUND;
        end
      end
      FUNC_LOOKUP: begin
        if (slot_hit) begin
          index_d = slot_idx_rd_q;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      FUNC_RLOOK: begin
        if (rev_valid_q[tix_q]) begin
          pid_d = rev_pid_rd_q;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Result register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_o         <= status_d;
      index_out_o      <= index_d;
      pid_out_o        <= pid_d;
      threads_issued_o <= issued_d;
      threads_active_o <= active_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

### design/pid_thread_index_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_thread_index_map: process id to dense thread index map
// Direct-mapped hash table with reverse index table and thread counters.
// ----------------------------------------------------------------------------
// Each operation goes through capture, table read and execute: the pid is
// hashed by a 22 by 32 bit multiply whose top bits are registered when the
// transfer is accepted, the slot and reverse tables are read through their
// synchronous memory port in the next cycle, and the operation is decided and
// written back in the execute state once the result register can take it.
// One operation is in flight at a time; a finished result waits in its own
// output register, so the next transfer is accepted while it waits.
// The thread limit register may be written at any time the block is idle.
module pid_thread_index_map
  import pitm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CNT_W-1:0]    cfg_thread_limit_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [PID_W-1:0]    pid_key_i,
  input  logic [IDX_W-1:0]    thread_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [IDX_W-1:0]    index_out_o,
  output logic [PID_W-1:0]    pid_out_o,
  output logic [CNT_W-1:0]    threads_issued_o,
  output logic [CNT_W-1:0]    threads_active_o
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  pitm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pitm_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_we_i           (cfg_valid_i),
    .cfg_thread_limit_i (cfg_thread_limit_i),
    .func_i             (func_i),
    .pid_key_i          (pid_key_i),
    .thread_index_i     (thread_index_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .index_out_o        (index_out_o),
    .pid_out_o          (pid_out_o),
    .threads_issued_o   (threads_issued_o),
    .threads_active_o   (threads_active_o)
  );

endmodule
